@@ design/shuffled_minimal_standard_rng_defines.svh @@
// Assertion macros shared by the checker of the shuffled minimal standard generator.
// No dependencies; included by design/smsrng_checker.sv.
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMSRNG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SMSRNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/smsrng_pkg.sv @@
// Package for the shuffled minimal standard generator: widths, constants and types.
// No dependencies; imported by every module of the block but smsrng_ram.
package smsrng_pkg;

  localparam int VALUE_W = 31;
  localparam int MUL_W   = 15;
  localparam int PROD_W  = VALUE_W + MUL_W;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int EXTRA_WARMUP_DEF  = 8;

  localparam logic [MUL_W-1:0]   LEHMER_MUL = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] OUT_LIMIT  = 31'd2147483389;

  // Register index codes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_SEED = 1'b0;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

@@ design/shuffled_minimal_standard_rng.sv @@
// Top level of the shuffled minimal standard generator: sequencer, registers, APB port.
// Depends on smsrng_pkg, smsrng_step, smsrng_div and smsrng_ram.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    reseed
//   out       source     out_valid/out_ready  random_value
//   apb       slave      psel/penable/pready  paddr, pwdata, prdata
//
// A draw runs through six sequencer states (multiply, fold, bucket index, table read,
// table write, output load) and then returns to idle, where the next beat is taken.
// A warm-up, on the first beat after reset or on reseed, first runs TABLE_ENTRIES+
// EXTRA_WARMUP_STEPS steps of the shared multiply-fold unit, each a multiply and a fold state.
// One beat is in work at a time and in_ready is high only in idle; a stalled result holds
// the sequencer in its output state. Reset is synchronous; warm-up fills the table first.
module shuffled_minimal_standard_rng import smsrng_pkg::*; #(
  parameter int TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
  parameter int EXTRA_WARMUP_STEPS = EXTRA_WARMUP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              reseed,
  output logic              out_valid,
  input  logic              out_ready,
  output value_t            random_value
);

  localparam int AW         = $clog2(TABLE_ENTRIES);
  localparam int WARM_STEPS = TABLE_ENTRIES + EXTRA_WARMUP_STEPS;
  localparam int CW         = $clog2(WARM_STEPS);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_WARM_MUL  = 9'b000000010,
    ST_WARM_RED  = 9'b000000100,
    ST_DRAW_MUL  = 9'b000001000,
    ST_DRAW_RED  = 9'b000010000,
    ST_DIV_WAIT  = 9'b000100000,
    ST_READ      = 9'b001000000,
    ST_WRITE     = 9'b010000000,
    ST_OUT       = 9'b100000000
  } state_t;

  state_t         state, state_next;
  value_t         seed;
  value_t         seed_fixed;
  value_t         lcg;
  value_t         last_pick;
  logic [CW-1:0]  count;
  value_t         step_result;
  logic           div_start;
  logic           div_busy;
  logic [AW-1:0]  div_idx;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  value_t         ram_wdata;
  logic           ram_re;
  value_t         ram_rdata;
  logic           in_fire;
  logic           cfg_write;
  logic           out_load;
  logic           warm_in_table;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[ADDR_W-1:2] == REG_SEED) ? {1'b0, seed} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= value_t'(1);
    end else if (cfg_write && paddr[ADDR_W-1:2] == REG_SEED) begin
      seed <= pwdata[VALUE_W-1:0];
    end
  end

  // Zero and the modulus itself both start the generator at one.
  assign seed_fixed = (seed == '0 || seed == LEHMER_MOD) ? value_t'(1) : seed;

  assign in_ready      = (state == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_load      = (state == ST_OUT) && (!out_valid || out_ready);
  assign warm_in_table = {1'b0, count} < (CW+1)'(TABLE_ENTRIES);
  assign div_start     = (state == ST_DRAW_MUL);

  smsrng_step u_step (
    .clk     (clk),
    .operand (lcg),
    .result  (step_result)
  );

  smsrng_div #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (last_pick),
    .busy     (div_busy),
    .idx      (div_idx)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = step_result;
    ram_re    = (state == ST_READ);
    if (state == ST_WARM_RED && warm_in_table) begin
      ram_we = 1'b1;
    end else if (state == ST_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = div_idx;
      ram_wdata = lcg;
    end
  end

  smsrng_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (div_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (reseed || last_pick == '0) ? ST_WARM_MUL : ST_DRAW_MUL;
        end
      end
      ST_WARM_MUL: state_next = ST_WARM_RED;
      ST_WARM_RED: state_next = (count == '0) ? ST_DRAW_MUL : ST_WARM_MUL;
      ST_DRAW_MUL: state_next = ST_DRAW_RED;
      ST_DRAW_RED: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcg       <= '0;
      last_pick <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && (reseed || last_pick == '0)) begin
        lcg <= seed_fixed;
      end else if (state == ST_WARM_RED || state == ST_DRAW_RED) begin
        lcg <= step_result;
      end
      // The last warm-up step is table entry zero, which is the first pick.
      if (state == ST_WARM_RED && count == '0) begin
        last_pick <= step_result;
      end else if (state == ST_WRITE) begin
        last_pick <= ram_rdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      count <= CW'(WARM_STEPS - 1);
    end else if (state == ST_WARM_RED && count != '0) begin
      count <= count - 1'b1;
    end
    if (out_load) begin
      random_value <= (last_pick > OUT_LIMIT) ? OUT_LIMIT : last_pick;
    end
  end

endmodule

@@ design/smsrng_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module smsrng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/smsrng_step.sv @@
// Shared Lehmer step unit: multiply by 16807, register, then fold modulo 2^31-1.
// Depends on smsrng_pkg.
module smsrng_step import smsrng_pkg::*; (
  input  logic   clk,
  input  value_t operand,
  output value_t result
);

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W:0]   fold;
  logic [VALUE_W:0]   fold_sub;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(operand) * PROD_W'(LEHMER_MUL);
  end

  // 2^31 is 1 modulo 2^31-1, so the high part folds onto the low part.
  always_comb begin
    fold     = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(prod[PROD_W-1:VALUE_W]);
    fold_sub = fold - {1'b0, LEHMER_MOD};
    result   = (fold >= {1'b0, LEHMER_MOD}) ? fold_sub[VALUE_W-1:0] : fold[VALUE_W-1:0];
  end

endmodule

@@ design/smsrng_div.sv @@
// Bucket index unit: scales a value by the entry count, then corrects the estimate by at most
// one after comparing it against the bucket bounds. Depends on smsrng_pkg.
module smsrng_div import smsrng_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  value_t                           dividend,
  output logic                             busy,
  output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int QW = $clog2(TABLE_ENTRIES + 1) + 1;
  localparam int DW = VALUE_W + QW;
  localparam longint BUCKET_DIV = 1 + 64'd2147483646 / TABLE_ENTRIES;

  value_t          held;
  logic [QW-1:0]   q_est;
  logic [QW-1:0]   quo;
  logic [DW-1:0]   scaled;
  logic [DW-1:0]   lower;
  logic [DW-1:0]   upper;

  // The bucket size times the entry count lies within the entry count of 2^31, so the
  // scaled estimate is at most one away from the true quotient.
  always_comb begin
    scaled = DW'(dividend) * DW'(TABLE_ENTRIES);
    lower  = DW'(q_est) * DW'(BUCKET_DIV);
    upper  = lower + DW'(BUCKET_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held  <= dividend;
      q_est <= scaled[DW-1:VALUE_W];
    end else if (busy) begin
      if (lower > DW'(held)) begin
        quo <= q_est - QW'(1);
      end else if (upper <= DW'(held)) begin
        quo <= q_est + QW'(1);
      end else begin
        quo <= q_est;
      end
    end
  end

  // A quotient past the table saturates to the last entry.
  assign idx = (quo >= QW'(TABLE_ENTRIES)) ? AW'(TABLE_ENTRIES - 1) : quo[AW-1:0];

endmodule

@@ design/smsrng_checker.sv @@
// Port-level checker for the shuffled minimal standard generator, bound to the top level.
// Depends on smsrng_pkg and shuffled_minimal_standard_rng_defines.svh.
`include "shuffled_minimal_standard_rng_defines.svh"

module smsrng_checker import smsrng_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input value_t            random_value
);

  // A shown result is never zero and never above the clamp limit.
  `SMSRNG_ASSERT_SAME(a_value_range, clk, rst, out_valid, (random_value != '0 && random_value <= OUT_LIMIT), "result beat out of range")

  // Each beat keeps the sequencer busy for at least the cycle after it is taken.
  `SMSRNG_ASSERT_NEXT(a_busy_after_accept, clk, rst, (in_valid && in_ready), !in_ready, "input taken twice in a row")

  // A stalled result beat stays put.
  `SMSRNG_ASSERT_NEXT(a_out_hold, clk, rst, (out_valid && !out_ready), (out_valid && $stable(random_value)), "stalled result changed")

  // A seed write reads back on the next cycle.
  `SMSRNG_ASSERT_NEXT(a_seed_readback, clk, rst, (psel && penable && pwrite && pready && paddr[2] == 1'b0), (paddr[2] || prdata[30:0] == $past(pwdata[30:0])), "seed readback mismatch")

endmodule

bind shuffled_minimal_standard_rng smsrng_checker u_smsrng_checker (.*);

@@ sim/shuffled_minimal_standard_rng_test.sv @@
// Self-checking testbench for the shuffled minimal standard generator.
// Holds its own predictor of the Lehmer step and shuffle table and drives beats through
// a bursty sender, a stalling receiver and the APB seed register; needs smsrng_pkg and the top level.
module shuffled_minimal_standard_rng_test;
  import smsrng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int WARM_STEPS = TABLE_ENTRIES_DEF + EXTRA_WARMUP_DEF;
  localparam longint unsigned BUCKET_DIV =
    64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_ENTRIES_DEF);
  // Multiplicative inverse of 16807 modulo 2^31-1, used to walk the generator backwards.
  localparam longint unsigned LEHMER_INV = 64'd1407677000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;
  localparam logic [ADDR_W-1:0] SEED_ADDR   = {REG_SEED, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = {REG_UNUSED, 2'b00};
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_DRAWS   = 172;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              reseed = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  value_t            random_value;

  shuffled_minimal_standard_rng #(
    .TABLE_ENTRIES     (TABLE_ENTRIES_DEF),
    .EXTRA_WARMUP_STEPS(EXTRA_WARMUP_DEF)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .reseed      (reseed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_value(random_value)
  );

  always #5 clk = ~clk;

  // Predicted generator state.
  value_t gen_seed = 31'd1;
  value_t gen_state = '0;
  value_t gen_last = '0;
  value_t gen_table [N_ENTRIES];

  logic   draw_requests [$];
  value_t expected_values [$];
  int     mismatch_count = 0;

  function automatic value_t lehmer_advance(input value_t s);
    return value_t'((64'(s) * 64'(LEHMER_MUL)) % 64'(LEHMER_MOD));
  endfunction

  function automatic value_t lehmer_retreat(input value_t s);
    return value_t'((64'(s) * LEHMER_INV) % 64'(LEHMER_MOD));
  endfunction

  function automatic void reload_table();
    value_t s;
    s = gen_seed;
    if (s == '0 || s == LEHMER_MOD) s = 31'd1;
    for (int j = WARM_STEPS - 1; j >= 0; j--) begin
      s = lehmer_advance(s);
      if (j < N_ENTRIES) gen_table[j] = s;
    end
    gen_state = s;
    gen_last = gen_table[0];
  endfunction

  function automatic value_t draw_next_value(input logic reseed_bit);
    int unsigned slot;
    value_t picked;
    if (reseed_bit || gen_last == '0) reload_table();
    gen_state = lehmer_advance(gen_state);
    slot = int'(64'(gen_last) / BUCKET_DIV);
    if (slot >= N_ENTRIES) slot = N_ENTRIES - 1;
    picked = gen_table[slot];
    gen_table[slot] = gen_state;
    gen_last = picked;
    return (picked > OUT_LIMIT) ? OUT_LIMIT : picked;
  endfunction

  // Finds a seed whose warm-up leaves a value above the clamp limit in the very slot
  // that the first draw reads, so that the clamp is hit on that draw.
  function automatic value_t find_clamp_seed();
    value_t x;
    value_t t;
    value_t s;
    for (int k = 1; k <= int'(LEHMER_MOD - OUT_LIMIT) - 1; k++) begin
      x = OUT_LIMIT + value_t'(k);
      t = x;
      for (int j = 1; j < N_ENTRIES; j++) begin
        t = lehmer_advance(t);
        if (64'(t) / BUCKET_DIV == 64'(j)) begin
          s = x;
          for (int n = 0; n < WARM_STEPS - j; n++) s = lehmer_retreat(s);
          return s;
        end
      end
    end
    return 31'd1;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_SEED) gen_seed = data[VALUE_W-1:0];
  endtask

  task automatic check_seed_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SEED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {1'b0, gen_seed}) note_mismatch("seed_value readback", prdata, gen_seed);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Looks at the falling edge, after every update of the rising edge has settled.
  task automatic wait_drained();
    while (draw_requests.size() != 0 || in_valid || expected_values.size() != 0)
      @(negedge clk);
  endtask

  // Queues n beats, bit i of pattern giving the reseed of beat i, and lets them finish.
  task automatic issue_draws(input logic [7:0] pattern, input int n);
    for (int i = 0; i < n; i++) draw_requests.push_back(pattern[i]);
    wait_drained();
  endtask

  // Sender: bursts of random length separated by random gaps.
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin : drive_beats
    logic offer;
    logic next_bit;
    if (rst) begin
      in_valid <= 1'b0;
      reseed <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_values.push_back(draw_next_value(reseed));
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        next_bit = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (draw_requests.size() > 0) begin
          offer = 1'b1;
          next_bit = draw_requests.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= offer;
        if (offer) reseed <= next_bit;
      end
    end
  end

  // Receiver: checks each beat and stalls on a pattern of changing modes, with two long
  // hold-offs that back the block up into its input.
  int       results_seen = 0;
  int       hold_left = 0;
  int       holds_done = 0;
  int       next_hold_at = 200;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin : watch_results
    logic   rdy;
    value_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          note_mismatch("unexpected random_value", random_value, 0);
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) note_mismatch("random_value", random_value, want);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_done < 2 && results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        holds_done++;
        next_hold_at += 600;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN: rdy = 1'b1;
          RX_HALF: rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] seed_word;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Cold start on the reset seed: the first beat warms up without a reseed.
    check_seed_readback();
    issue_draws(8'b0_1000, 5);

    apb_write(SEED_ADDR, 32'h0000_0000);
    check_seed_readback();
    issue_draws(8'b001, 3);

    // The modulus itself is congruent to zero; the second write reaches it only by masking.
    apb_write(SEED_ADDR, 32'h7FFF_FFFF);
    check_seed_readback();
    issue_draws(8'b01, 2);
    apb_write(SEED_ADDR, 32'hFFFF_FFFF);
    check_seed_readback();
    issue_draws(8'b01, 2);

    apb_write(SEED_ADDR, 32'd2147483646);
    issue_draws(8'b011, 3);

    // A write to any other register leaves the seed alone.
    apb_write(UNUSED_ADDR, $urandom);
    check_seed_readback();
    issue_draws(8'b1, 1);

    apb_write(SEED_ADDR, {1'b0, find_clamp_seed()});
    issue_draws(8'b0001, 4);

    apb_write(SEED_ADDR, 32'h8000_0000);
    check_seed_readback();
    issue_draws(8'b01, 2);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: seed_word = 32'h0000_0000;
        1: seed_word = 32'h7FFF_FFFF;
        2: seed_word = 32'd2147483646;
        3: seed_word = 32'h0000_0001;
        default: seed_word = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) apb_write(UNUSED_ADDR, $urandom);
      apb_write(SEED_ADDR, seed_word);
      check_seed_readback();
      for (int i = 0; i < PHASE_DRAWS; i++)
        draw_requests.push_back($urandom_range(0, 11) == 0);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("shuffled_minimal_standard_rng: match");
    end else begin
      $display("shuffled_minimal_standard_rng: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("shuffled_minimal_standard_rng: mismatch");
    $finish;
  end

endmodule
